FILE: hdl/rlpm_pkg.sv
// Package for the run-length periodicity metric: sizes, codes, FSM states
// and the control/status structs passed between the sequencer and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlpm_pkg;

    // Fixed sizes
    localparam int RUN_BITS   = 16;
    localparam int MAX_RUNS   = 4096;
    localparam int FRAC_BITS  = 8;
    localparam int MEAN_W     = 24;
    localparam int CNT_W      = $clog2(MAX_RUNS + 1);
    localparam int SUM_W      = RUN_BITS + $clog2(MAX_RUNS);
    localparam int DVD_W      = SUM_W + FRAC_BITS;
    localparam int DBIT_W     = $clog2(DVD_W);
    localparam int ALU_W      = SUM_W;

    // Lead-in/lead-out handling
    localparam int DIV_OFFSET = 3;   // second-diff count = runs before last - 3
    localparam int MIN_RUNS   = 4;   // fewer runs before last: no second diff

    localparam logic [MEAN_W-1:0] ERR_VALUE = MEAN_W'(65311);

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_FEW  = 2'd1,
        STS_MANY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ALU_ABSDIFF,
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [2:0] {
        OPS_RUN_PREV,
        OPS_D_PFD,
        OPS_SUM_E,
        OPS_CNT_OFS,
        OPS_DIV
    } opsel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF1,
        S_DIFF2,
        S_ACC,
        S_UPD,
        S_CNT,
        S_DIV,
        S_FIN
    } state_t;

    // Sequencer -> datapath
    typedef struct packed {
        alu_op_t alu_op;
        opsel_t  opsel;
        logic    cnt_inc;
        logic    early_prev;
        logic    ld_d;
        logic    ld_e;
        logic    ld_sum;
        logic    upd;
        logic    div_init;
        logic    div_step;
        logic    ld_sts;
        status_t sts;
        logic    res_ld;
    } ctl_t;

    // Datapath -> sequencer
    typedef struct packed {
        logic accept;
        logic last;
        logic cnt_full;
        logic cnt_is0;
        logic cnt_is1;
        logic cnt_ge3;
        logic few_or_zero;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

FILE: hdl/run_length_periodicity_metric_top.sv
// Top level of the run-length periodicity metric: datapath registers,
// operand muxing and the output register. Uses rlpm_pkg, rlpm_ctrl, rlpm_alu.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Slave channel s_*: one word per run, s_tdata = run length, s_tlast marks
//   the final run of a sequence. The first and final runs are lead-in/out.
//   Master channel m_*: one word per sequence, given on the final run:
//   m_tdata = mean absolute second difference (8 fraction bits, truncated),
//   m_tuser = status (0 ok, 1 too few runs or zero sum, 2 too many runs).
//   On any error m_tdata carries 65311.
// Sequencing (one shared ALU, one word in flight):
//   first two runs of a sequence: counted in the idle state, s_tready stays high.
//   third run: absdiff, update; later runs: absdiff, absdiff, add, update.
//   final run, error: the result step loads the output register and returns
//   to idle.
//   final run, ok: divisor load, then the restoring divide with one quotient
//   bit per ALU pass, then the result step.
// Reset: aresetn low clears the sequence state and drops m_tvalid.
// Stall: the result sits in an output register; new runs are accepted while
//   it waits. A following final run holds in its result step until m_tready.
module run_length_periodicity_metric_top
    import rlpm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] run_len
    input  wire logic        s_tlast,   // last_run
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [23:0] mean_second_diff
    output logic      [1:0]  m_tuser    // [1:0] status
);

    ctl_t ctl;
    sts_t sts;

    logic [RUN_BITS-1:0] run_reg, run_next;
    logic [RUN_BITS-1:0] prev_run_reg, prev_run_next;
    logic [RUN_BITS-1:0] pfd_reg, pfd_next;     // previous first difference
    logic [RUN_BITS-1:0] d_reg, d_next;         // current first difference
    logic [RUN_BITS-1:0] e_reg, e_next;         // current second difference
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    divisor_reg, divisor_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;     // dividend in, quotient out
    status_t             sts_reg, sts_next;
    logic                m_valid_reg, m_valid_next;
    logic [MEAN_W-1:0]   m_mean_reg, m_mean_next;
    status_t             m_sts_reg, m_sts_next;

    logic [ALU_W-1:0]    alu_a, alu_b, alu_y;
    logic                alu_borrow;
    logic [CNT_W:0]      rem_shift;
    logic                accept;
    logic [MEAN_W-1:0]   quot_sat;

    assign accept    = s_tvalid && s_tready;
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign quot_sat  = (|dvd_reg[DVD_W-1:MEAN_W]) ? '1 : dvd_reg[MEAN_W-1:0];

    assign sts.accept      = accept;
    assign sts.last        = s_tlast;
    assign sts.cnt_full    = (cnt_reg >= CNT_W'(MAX_RUNS));
    assign sts.cnt_is0     = (cnt_reg == '0);
    assign sts.cnt_is1     = (cnt_reg == CNT_W'(1));
    assign sts.cnt_ge3     = (cnt_reg >= CNT_W'(DIV_OFFSET));
    assign sts.few_or_zero = (cnt_reg < CNT_W'(MIN_RUNS)) || (sum_reg == '0);
    assign sts.out_busy    = m_valid_reg && !m_tready;

    rlpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .ctl     (ctl),
        .s_ready (s_tready)
    );

    // Operand select for the shared ALU
    always_comb begin
        case (ctl.opsel)
            OPS_RUN_PREV: begin
                alu_a = ALU_W'(run_reg);
                alu_b = ALU_W'(prev_run_reg);
            end
            OPS_D_PFD: begin
                alu_a = ALU_W'(d_reg);
                alu_b = ALU_W'(pfd_reg);
            end
            OPS_SUM_E: begin
                alu_a = ALU_W'(sum_reg);
                alu_b = ALU_W'(e_reg);
            end
            OPS_CNT_OFS: begin
                alu_a = ALU_W'(cnt_reg);
                alu_b = ALU_W'(DIV_OFFSET);
            end
            OPS_DIV: begin
                alu_a = ALU_W'(rem_shift);
                alu_b = ALU_W'(divisor_reg);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    rlpm_alu u_alu (
        .op     (ctl.alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .y      (alu_y),
        .borrow (alu_borrow)
    );

    // Datapath next values
    always_comb begin
        run_next      = run_reg;
        prev_run_next = prev_run_reg;
        pfd_next      = pfd_reg;
        d_next        = d_reg;
        e_next        = e_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        sts_next      = sts_reg;

        if (accept) begin
            run_next = RUN_BITS'(s_tdata);
        end
        if (ctl.early_prev) begin
            prev_run_next = RUN_BITS'(s_tdata);
        end
        if (ctl.ld_d) begin
            d_next = alu_y[RUN_BITS-1:0];
        end
        if (ctl.ld_e) begin
            e_next = alu_y[RUN_BITS-1:0];
        end
        if (ctl.ld_sum) begin
            sum_next = alu_y[SUM_W-1:0];
        end
        if (ctl.upd) begin
            pfd_next      = d_reg;
            prev_run_next = run_reg;
        end
        if (ctl.cnt_inc) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (ctl.ld_sts) begin
            sts_next = ctl.sts;
        end
        // restoring divide: one quotient bit per cycle into the dividend LSB
        if (ctl.div_init) begin
            divisor_next = alu_y[CNT_W-1:0];
            rem_next     = '0;
            dvd_next     = {sum_reg, FRAC_BITS'(0)};
        end else if (ctl.div_step) begin
            rem_next = alu_borrow ? rem_shift[CNT_W-1:0] : alu_y[CNT_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], !alu_borrow};
        end
        // sequence done: back to the reset state
        if (ctl.res_ld) begin
            prev_run_next = '0;
            pfd_next      = '0;
            cnt_next      = '0;
            sum_next      = '0;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_mean_next  = m_mean_reg;
        m_sts_next   = m_sts_reg;
        if (ctl.res_ld) begin
            m_valid_next = 1'b1;
            m_sts_next   = sts_reg;
            m_mean_next  = (sts_reg == STS_OK) ? quot_sat : ERR_VALUE;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_run_reg <= '0;
            pfd_reg      <= '0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            prev_run_reg <= prev_run_next;
            pfd_reg      <= pfd_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_reg     <= run_next;
        d_reg       <= d_next;
        e_reg       <= e_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        sts_reg     <= sts_next;
        m_mean_reg  <= m_mean_next;
        m_sts_reg   <= m_sts_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_mean_reg;
    assign m_tuser  = m_sts_reg;

    a_cnt_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RUNS))
        else $error("run counter passed its saturation limit");

    a_err_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STS_OK) |-> (m_tdata == ERR_VALUE))
        else $error("error status without error value");

    a_res_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.res_ld |=> (m_tvalid && cnt_reg == '0 && sum_reg == '0))
        else $error("result load did not present word or clear sequence");

endmodule

`default_nettype wire

FILE: hdl/rlpm_alu.sv
// Shared arithmetic unit: absolute difference, add, subtract with borrow.
// Depends on rlpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpm_alu
    import rlpm_pkg::*;
(
    input  wire alu_op_t          op,
    input  wire logic [ALU_W-1:0] a,
    input  wire logic [ALU_W-1:0] b,
    output logic      [ALU_W-1:0] y,
    output logic                  borrow
);

    logic a_lt_b;

    assign a_lt_b = (a < b);
    assign borrow = a_lt_b;

    always_comb begin
        case (op)
            ALU_ABSDIFF: y = a_lt_b ? (b - a) : (a - b);
            ALU_ADD:     y = a + b;
            ALU_SUB:     y = a - b;
            default:     y = a - b;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/rlpm_ctrl.sv
// Sequencer for the metric: walks each word through the shared ALU and runs
// the restoring divide one quotient bit per cycle. Depends on rlpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpm_ctrl
    import rlpm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire sts_t sts,
    output ctl_t      ctl,
    output logic      s_ready
);

    state_t              state_reg, state_next;
    logic [DBIT_W-1:0]   bit_reg, bit_next;
    logic                div_done;

    assign div_done = (bit_reg == DBIT_W'(DVD_W - 1));
    assign s_ready  = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb begin
        bit_next = bit_reg;
        if (ctl.div_init) begin
            bit_next = '0;
        end else if (ctl.div_step) begin
            bit_next = bit_reg + 1'b1;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (sts.accept) begin
                    if (sts.last) begin
                        state_next = (sts.cnt_full || sts.few_or_zero) ? S_FIN : S_CNT;
                    end else if (!sts.cnt_full && !sts.cnt_is0 && !sts.cnt_is1) begin
                        state_next = S_DIFF1;
                    end
                end
            end
            S_DIFF1: state_next = sts.cnt_ge3 ? S_DIFF2 : S_UPD;
            S_DIFF2: state_next = S_ACC;
            S_ACC:   state_next = S_UPD;
            S_UPD:   state_next = S_IDLE;
            S_CNT:   state_next = S_DIV;
            S_DIV:   state_next = div_done ? S_FIN : S_DIV;
            S_FIN:   state_next = sts.out_busy ? S_FIN : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        ctl        = '0;
        ctl.alu_op = ALU_ADD;
        ctl.opsel  = OPS_SUM_E;
        ctl.sts    = STS_OK;
        case (state_reg)
            S_IDLE: begin
                if (sts.accept) begin
                    if (sts.last) begin
                        ctl.ld_sts = 1'b1;
                        if (sts.cnt_full) begin
                            ctl.sts = STS_MANY;
                        end else if (sts.few_or_zero) begin
                            ctl.sts = STS_FEW;
                        end else begin
                            ctl.sts = STS_OK;
                        end
                    end else if (!sts.cnt_full) begin
                        // first run is lead-in; second run seeds prev_run
                        if (sts.cnt_is0) begin
                            ctl.cnt_inc = 1'b1;
                        end else if (sts.cnt_is1) begin
                            ctl.cnt_inc    = 1'b1;
                            ctl.early_prev = 1'b1;
                        end
                    end
                end
            end
            S_DIFF1: begin
                ctl.alu_op = ALU_ABSDIFF;
                ctl.opsel  = OPS_RUN_PREV;
                ctl.ld_d   = 1'b1;
            end
            S_DIFF2: begin
                ctl.alu_op = ALU_ABSDIFF;
                ctl.opsel  = OPS_D_PFD;
                ctl.ld_e   = 1'b1;
            end
            S_ACC: begin
                ctl.alu_op = ALU_ADD;
                ctl.opsel  = OPS_SUM_E;
                ctl.ld_sum = 1'b1;
            end
            S_UPD: begin
                ctl.upd     = 1'b1;
                ctl.cnt_inc = 1'b1;
            end
            S_CNT: begin
                ctl.alu_op   = ALU_SUB;
                ctl.opsel    = OPS_CNT_OFS;
                ctl.div_init = 1'b1;
            end
            S_DIV: begin
                ctl.alu_op   = ALU_SUB;
                ctl.opsel    = OPS_DIV;
                ctl.div_step = 1'b1;
            end
            S_FIN: begin
                ctl.res_ld = !sts.out_busy;
            end
            default: begin
                ctl.alu_op = ALU_ADD;
            end
        endcase
    end

    a_div_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (bit_reg <= DBIT_W'(DVD_W - 1)))
        else $error("divide bit counter overran");

    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && div_done) |=> (state_reg == S_FIN))
        else $error("divide did not finish after last bit");

    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CNT) |=> (state_reg == S_DIV && bit_reg == '0))
        else $error("divide started without clearing bit counter");

    a_fin_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && !sts.out_busy) |=> (state_reg == S_IDLE))
        else $error("result stage did not release");

endmodule

`default_nettype wire
